>>> sv/lsr_pkg.sv
`timescale 1ns / 1ps
// Package for the LIFO stack with reverse: request and response structs,
// operation codes and controller states. No dependencies.
package lsr_pkg;

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_PEEK    = 2'd2,
      OP_REVERSE = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic               success;
      logic signed [31:0] top_value;
      logic [4:0]         entry_count;
      logic               is_empty;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_REV_RD_LO,
      ST_REV_RD_HI,
      ST_REV_WR_LO,
      ST_REV_WR_HI
   } state_type;

endpackage

>>> sv/lifo_stack_with_reverse.sv
`timescale 1ns / 1ps
// LIFO stack with reverse: top level holding the entry memory and its controller.
// Depends on lsr_pkg for the request/response structs, opcodes and states.

// A request is taken when start is high and busy is low; each request yields
// exactly one response, shown for one cycle with rsp_strobe high, and the
// receiver cannot stall it. A push, or any request that fails, answers in the
// next cycle and keeps busy low, so these can be issued every cycle. A pop or
// peek needs one read of the entry memory: busy is high for one cycle, in
// ST_READ, and the response is registered from that state. A reverse of
// n entries swaps floor(n/2) entry pairs through the memory's read and write
// ports, stepping through the read lo, read hi, write lo and write hi states
// for each pair, and the response appears in the first cycle with busy low.
module lifo_stack_with_reverse
   import lsr_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int WORD_BITS   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [WORD_BITS-1:0] mem [STACK_DEPTH];

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [WORD_BITS-1:0] tmp_ff, tmp_in;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 not_empty, not_full, rev_more;
   logic [CW-1:0]        count_m1;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic                 rsp_ok;
   logic                 rsp_has_value;
   logic [WORD_BITS+31:0] push_wide;
   logic [WORD_BITS+31:0] rd_wide;
   logic [CW+4:0]         count_wide;

   assign accept    = start && (state_ff == ST_IDLE);
   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff < CW'(STACK_DEPTH));
   assign count_m1  = count_ff - CW'(1);
   // Another pair remains once lo and hi have both stepped inward.
   assign rev_more  = (hi_ff - AW'(1)) > (lo_ff + AW'(1));

   assign push_wide  = {{WORD_BITS{1'b0}}, req_payload.push_value};
   assign rd_wide    = {32'b0, rd_data_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_payload.opcode)
                  OP_POP, OP_PEEK: if (not_empty) state_in = ST_READ;
                  OP_REVERSE:      if (count_ff > CW'(1)) state_in = ST_REV_RD_LO;
                  default:         state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:      state_in = ST_IDLE;
         ST_REV_RD_LO: state_in = ST_REV_RD_HI;
         ST_REV_RD_HI: state_in = ST_REV_WR_LO;
         ST_REV_WR_LO: state_in = ST_REV_WR_HI;
         ST_REV_WR_HI: state_in = rev_more ? ST_REV_RD_LO : ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      tmp_in        = tmp_ff;
      rd_addr       = lo_ff;
      wr_en         = 1'b0;
      wr_addr       = lo_ff;
      wr_data       = rd_data_ff;
      rsp_strobe_in = 1'b0;
      rsp_ok        = 1'b0;
      rsp_has_value = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_payload.opcode)
                  OP_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (not_full) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = push_wide[WORD_BITS-1:0];
                        count_in = count_ff + CW'(1);
                        rsp_ok   = 1'b1;
                     end
                  end
                  OP_POP: begin
                     rd_addr = count_m1[AW-1:0];
                     if (not_empty) count_in = count_m1;
                     else rsp_strobe_in = 1'b1;
                  end
                  OP_PEEK: begin
                     rd_addr = count_m1[AW-1:0];
                     if (!not_empty) rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     lo_in = '0;
                     hi_in = count_m1[AW-1:0];
                     if (count_ff <= CW'(1)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_ok        = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_ok        = 1'b1;
            rsp_has_value = 1'b1;
         end
         ST_REV_RD_LO: rd_addr = lo_ff;
         ST_REV_RD_HI: begin
            rd_addr = hi_ff;
            tmp_in  = rd_data_ff;
         end
         ST_REV_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_data_ff;
         end
         ST_REV_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = tmp_ff;
            lo_in   = lo_ff + AW'(1);
            hi_in   = hi_ff - AW'(1);
            if (!rev_more) begin
               rsp_strobe_in = 1'b1;
               rsp_ok        = 1'b1;
            end
         end
         default: busy = 1'b1;
      endcase
   end

   assign count_wide = {5'b0, count_in};

   always_comb begin
      rsp_in.success     = rsp_ok;
      rsp_in.top_value   = rsp_has_value ? rd_wide[31:0] : 32'sd0;
      rsp_in.entry_count = count_wide[4:0];
      rsp_in.is_empty    = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      tmp_ff <= tmp_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("entry count above stack depth");

   a_rev_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REV_RD_LO || state_ff == ST_REV_RD_HI ||
       state_ff == ST_REV_WR_LO || state_ff == ST_REV_WR_HI) |-> (lo_ff < hi_ff))
      else $error("reverse pointers crossed");

   a_rev_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REV_RD_HI || state_ff == ST_REV_WR_LO ||
       state_ff == ST_REV_WR_HI) |-> !rsp_strobe)
      else $error("response during reverse");

   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (rsp_strobe && rsp_payload.success))
      else $error("pop or peek read without a response");

endmodule
